@@ rtl/plbi_pkg.sv @@
// Package with the shared types and constants of the parallel display bus interface.
`timescale 1ns / 1ps

package plbi_pkg;

    // Operation codes of an input item.
    typedef enum logic [2:0] {
        OP_CMD8       = 3'd0,
        OP_CMD16      = 3'd1,
        OP_DATA8      = 3'd2,
        OP_DATA16     = 3'd3,
        OP_BEGIN_READ = 3'd4,
        OP_READ_BYTE  = 3'd5,
        OP_END        = 3'd6
    } t_op;

    // Kinds of a result item.
    typedef enum logic [1:0] {
        KIND_WRITE   = 2'd0,
        KIND_READ    = 2'd1,
        KIND_RELEASE = 2'd2
    } t_kind;

    // Read assembly modes.
    typedef enum logic [1:0] {
        RMODE_BYTE   = 2'd0,
        RMODE_WORD   = 2'd1,
        RMODE_RGB565 = 2'd2
    } t_rmode;

    // One result item.
    typedef struct packed {
        t_kind       kind;
        logic        reg_select;
        logic [7:0]  bus_out;
        logic [15:0] read_word;
        logic        last;
    } t_result;

    localparam logic [7:0] RED_MASK   = 8'hF8;
    localparam logic [7:0] GREEN_MASK = 8'hFC;

    localparam int unsigned RES_BITS = $bits(t_result);

endpackage

@@ rtl/parallel_lcd_bus_interface_top.sv @@
// Top level of the 8-bit 8080-style parallel display bus interface.
`timescale 1ns / 1ps

// Turns command, data and read items into the byte-level activity of an 8-bit
// 8080-style display bus. Command and data items become bus write cycles (register
// select low for commands, high for data); a 16-bit value becomes two write cycles,
// high byte first, or low byte first when the swap_byte_order register (address 0)
// is set. A begin-read item switches to read direction and discards the given number
// of dummy bytes; the read samples that follow are assembled into 8-bit words,
// 16-bit words or RGB565 words packed from three RGB888 bytes. An end item releases
// chip select and yields one release result. The block accepts one input item per
// clock cycle while the queue has room and produces one result item per cycle on
// its output while the receiver is ready: an item that yields two writes therefore
// puts two result items on the output, and that single-result-per-cycle output
// port sets the sustained rate. An accepted item waits in the input register and
// is then written into the four-entry result queue, after which its first result
// is offered. The input is held off while the queue, after the result taken in the
// same cycle, would have fewer than two free entries.
// The queue lets new items enter while earlier results still wait to be taken.
module parallel_lcd_bus_interface_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata, from bit 0: value[15:0], read_mode[17:16], dummy_count[21:18],
    // bus_byte[29:22], zero fill[31:30].
    input  logic [31:0] s_axis_tdata,
    // tuser, from bit 0: op[2:0].
    input  logic [2:0]  s_axis_tuser,
    // Result item stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata, from bit 0: bus_out[7:0], read_word[23:8].
    output logic [23:0] m_axis_tdata,
    // tuser, from bit 0: kind[1:0], reg_select[2].
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);

    // ------------------------------------------------------------------
    // Configuration register.
    // ------------------------------------------------------------------
    logic r_swap;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
    assign prdata = (paddr == 3'd0) ? {31'd0, r_swap} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap <= 1'b0;
        end else if (cfg_wr) begin
            r_swap <= pwdata[0];
        end
    end

    // ------------------------------------------------------------------
    // Input register.
    // ------------------------------------------------------------------
    logic        r_in_valid;
    logic [2:0]  r_in_op;
    logic [15:0] r_in_value;
    logic [1:0]  r_in_rmode;
    logic [3:0]  r_in_dcount;
    logic [7:0]  r_in_byte;
    logic        fire;
    logic        in_take;

    assign s_axis_tready = !r_in_valid || fire;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op     <= s_axis_tuser;
            r_in_value  <= s_axis_tdata[15:0];
            r_in_rmode  <= s_axis_tdata[17:16];
            r_in_dcount <= s_axis_tdata[21:18];
            r_in_byte   <= s_axis_tdata[29:22];
        end
    end

    // ------------------------------------------------------------------
    // Bus state and item processing.
    // ------------------------------------------------------------------
    logic        r_reading;
    logic [1:0]  r_mode;
    logic [3:0]  r_dummies;
    logic [1:0]  r_phase;
    logic [7:0]  r_held [2];

    logic        n_reading;
    logic [1:0]  n_mode;
    logic [3:0]  n_dummies;
    logic [1:0]  n_phase;
    logic        held_we;
    logic        held_idx;

    plbi_pkg::t_result res0;
    plbi_pkg::t_result res1;
    logic [1:0]        npush;

    always_comb begin
        logic        rs;
        logic [15:0] w;
        n_reading = r_reading;
        n_mode    = r_mode;
        n_dummies = r_dummies;
        n_phase   = r_phase;
        held_we   = 1'b0;
        held_idx  = 1'b0;
        npush     = 2'd0;
        res0      = '0;
        res1      = '0;
        rs        = r_in_op[1];
        w         = 16'd0;
        case (plbi_pkg::t_op'(r_in_op))
            plbi_pkg::OP_CMD8, plbi_pkg::OP_DATA8: begin
                n_reading       = 1'b0;
                n_phase         = 2'd0;
                npush           = 2'd1;
                res0.kind       = plbi_pkg::KIND_WRITE;
                res0.reg_select = rs;
                res0.bus_out    = r_in_value[7:0];
                res0.last       = 1'b1;
            end
            plbi_pkg::OP_CMD16, plbi_pkg::OP_DATA16: begin
                n_reading       = 1'b0;
                n_phase         = 2'd0;
                npush           = 2'd2;
                res0.kind       = plbi_pkg::KIND_WRITE;
                res0.reg_select = rs;
                res0.bus_out    = r_swap ? r_in_value[7:0] : r_in_value[15:8];
                res1.kind       = plbi_pkg::KIND_WRITE;
                res1.reg_select = rs;
                res1.bus_out    = r_swap ? r_in_value[15:8] : r_in_value[7:0];
                res1.last       = 1'b1;
            end
            plbi_pkg::OP_BEGIN_READ: begin
                n_reading = 1'b1;
                n_mode    = r_in_rmode;
                n_dummies = r_in_dcount;
                n_phase   = 2'd0;
            end
            plbi_pkg::OP_READ_BYTE: begin
                if (r_reading) begin
                    if (r_dummies != 4'd0) begin
                        n_dummies = r_dummies - 4'd1;
                    end else if (r_mode == plbi_pkg::RMODE_WORD) begin
                        if (r_phase == 2'd0) begin
                            held_we  = 1'b1;
                            held_idx = 1'b0;
                            n_phase  = 2'd1;
                        end else begin
                            n_phase        = 2'd0;
                            w              = r_swap ? {r_in_byte, r_held[0]}
                                                    : {r_held[0], r_in_byte};
                            npush          = 2'd1;
                            res0.kind      = plbi_pkg::KIND_READ;
                            res0.read_word = w;
                            res0.last      = 1'b1;
                        end
                    end else if (r_mode == plbi_pkg::RMODE_RGB565) begin
                        if (r_phase != 2'd2) begin
                            held_we  = 1'b1;
                            held_idx = r_phase[0];
                            n_phase  = r_phase + 2'd1;
                        end else begin
                            // Red and green keep their top bits, blue its top five.
                            n_phase = 2'd0;
                            w = {r_held[0][7:3] & plbi_pkg::RED_MASK[7:3],
                                 r_held[1][7:2] & plbi_pkg::GREEN_MASK[7:2],
                                 r_in_byte[7:3]};
                            if (r_swap) begin
                                w = {w[7:0], w[15:8]};
                            end
                            npush          = 2'd1;
                            res0.kind      = plbi_pkg::KIND_READ;
                            res0.read_word = w;
                            res0.last      = 1'b1;
                        end
                    end else begin
                        // Byte mode, and the unused fourth mode behaves the same.
                        npush          = 2'd1;
                        res0.kind      = plbi_pkg::KIND_READ;
                        res0.read_word = {8'd0, r_in_byte};
                        res0.last      = 1'b1;
                    end
                end
            end
            plbi_pkg::OP_END: begin
                n_reading = 1'b0;
                n_dummies = 4'd0;
                n_phase   = 2'd0;
                npush     = 2'd1;
                res0.kind = plbi_pkg::KIND_RELEASE;
                res0.last = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reading <= 1'b0;
            r_mode    <= 2'd0;
            r_dummies <= 4'd0;
            r_phase   <= 2'd0;
        end else if (fire) begin
            r_reading <= n_reading;
            r_mode    <= n_mode;
            r_dummies <= n_dummies;
            r_phase   <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && held_we) begin
            r_held[held_idx] <= r_in_byte;
        end
    end

    // ------------------------------------------------------------------
    // Result queue: up to two pushes and one pop per cycle.
    // ------------------------------------------------------------------
    logic [plbi_pkg::RES_BITS-1:0] r_q [QDEPTH];
    logic [QPTR_W-1:0]             r_wptr;
    logic [QPTR_W-1:0]             r_rptr;
    logic [QPTR_W:0]               r_count;
    logic                          pop;
    logic [QPTR_W:0]               kept;
    plbi_pkg::t_result             head;

    assign pop  = m_axis_tvalid && m_axis_tready;
    assign kept = r_count - {{QPTR_W{1'b0}}, pop};
    // Room for the worst case of two results must exist before an item is processed.
    assign fire = r_in_valid && (kept <= (QPTR_W + 1)'(QDEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_rptr  <= r_rptr + {{(QPTR_W-1){1'b0}}, pop};
            r_wptr  <= r_wptr + (fire ? npush[QPTR_W-1:0] : '0);
            r_count <= kept + (fire ? {{(QPTR_W-1){1'b0}}, npush} : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && (npush != 2'd0)) begin
            r_q[r_wptr] <= res0;
        end
        if (fire && (npush == 2'd2)) begin
            r_q[r_wptr + {{(QPTR_W-1){1'b0}}, 1'b1}] <= res1;
        end
    end

    assign head          = plbi_pkg::t_result'(r_q[r_rptr]);
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = {head.read_word, head.bus_out};
    assign m_axis_tuser  = {head.reg_select, head.kind};
    assign m_axis_tlast  = head.last;

endmodule

@@ rtl/plbi_checker.sv @@
// Port-level checker for the parallel display bus interface, bound to its top level.
`timescale 1ns / 1ps

module plbi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // Nothing is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered right after reset");

    // Only the three defined kinds appear.
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[1:0] != 2'd3))
        else $error("undefined result kind");

    // Read words and releases carry no write byte and no register select.
    a_nonwrite_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser[1:0] != plbi_pkg::KIND_WRITE))
        |-> (!m_axis_tuser[2] && (m_axis_tdata[7:0] == 8'd0) && m_axis_tlast))
        else $error("read or release result with write fields set");

    // A release and a write cycle carry no read word.
    a_noread_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser[1:0] != plbi_pkg::KIND_READ))
        |-> (m_axis_tdata[23:8] == 16'd0))
        else $error("read word set on a non-read result");

    // A stalled result stays unchanged.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind parallel_lcd_bus_interface_top plbi_checker u_plbi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

@@ dv/lcd_bus_check_pkg.sv @@
// Scoreboard package that predicts and checks the results of the display bus interface.
`timescale 1ns / 1ps

package lcd_bus_check_pkg;
    import plbi_pkg::*;

    // Op code seven has no meaning and must be dropped by the block.
    localparam logic [2:0] OP_UNUSED = 3'd7;
    // Read mode three has no name of its own and assembles like byte mode.
    localparam logic [1:0] RMODE_SPARE = 2'd3;
    // Stop printing mismatches after this many so a broken block cannot flood the log.
    localparam int unsigned REPORT_CAP = 40;

    // One input item, as the sender builds it.
    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] value;
        logic [1:0]  read_mode;
        logic [3:0]  dummy_count;
        logic [7:0]  bus_byte;
    } t_bus_item;

    class lcd_bus_scoreboard;
        t_result     expected_results[$];
        int unsigned errors;
        logic        swap_order;
        logic        cs_active;
        logic        in_read;
        logic [1:0]  assemble_mode;
        logic [3:0]  skip_left;
        logic [1:0]  byte_index;
        logic [7:0]  held[2];

        function new();
            errors        = 0;
            swap_order    = 1'b0;
            cs_active     = 1'b0;
            in_read       = 1'b0;
            assemble_mode = RMODE_BYTE;
            skip_left     = 4'd0;
            byte_index    = 2'd0;
            held[0]       = 8'h00;
            held[1]       = 8'h00;
        endfunction

        function void set_swap(logic swap);
            swap_order = swap;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function void push_result(t_kind kind, logic rs, logic [7:0] bus, logic [15:0] word,
                                  logic last);
            t_result r;
            r.kind       = kind;
            r.reg_select = rs;
            r.bus_out    = bus;
            r.read_word  = word;
            r.last       = last;
            expected_results.push_back(r);
        endfunction

        // Advances the predicted bus state by one accepted item and queues its results.
        function void note_accepted_item(t_bus_item it);
            logic        rs;
            logic [15:0] word;
            rs = (it.op == OP_DATA8) || (it.op == OP_DATA16);
            case (it.op)
                OP_CMD8, OP_DATA8: begin
                    cs_active  = 1'b1;
                    in_read    = 1'b0;
                    byte_index = 2'd0;
                    push_result(KIND_WRITE, rs, it.value[7:0], 16'h0000, 1'b1);
                end
                OP_CMD16, OP_DATA16: begin
                    cs_active  = 1'b1;
                    in_read    = 1'b0;
                    byte_index = 2'd0;
                    if (swap_order) begin
                        push_result(KIND_WRITE, rs, it.value[7:0], 16'h0000, 1'b0);
                        push_result(KIND_WRITE, rs, it.value[15:8], 16'h0000, 1'b1);
                    end else begin
                        push_result(KIND_WRITE, rs, it.value[15:8], 16'h0000, 1'b0);
                        push_result(KIND_WRITE, rs, it.value[7:0], 16'h0000, 1'b1);
                    end
                end
                OP_BEGIN_READ: begin
                    cs_active     = 1'b1;
                    in_read       = 1'b1;
                    assemble_mode = it.read_mode;
                    skip_left     = it.dummy_count;
                    byte_index    = 2'd0;
                end
                OP_READ_BYTE: begin
                    if (in_read) begin
                        if (skip_left != 4'd0) begin
                            skip_left = skip_left - 4'd1;
                        end else if (assemble_mode == RMODE_WORD) begin
                            if (byte_index == 2'd0) begin
                                held[0]    = it.bus_byte;
                                byte_index = 2'd1;
                            end else begin
                                byte_index = 2'd0;
                                word = swap_order ? {it.bus_byte, held[0]}
                                                  : {held[0], it.bus_byte};
                                push_result(KIND_READ, 1'b0, 8'h00, word, 1'b1);
                            end
                        end else if (assemble_mode == RMODE_RGB565) begin
                            if (byte_index < 2'd2) begin
                                held[byte_index[0]] = it.bus_byte;
                                byte_index          = byte_index + 2'd1;
                            end else begin
                                byte_index = 2'd0;
                                word = {held[0] & RED_MASK, 8'h00}
                                     | ({8'h00, held[1] & GREEN_MASK} << 3)
                                     | {11'd0, it.bus_byte[7:3]};
                                if (swap_order) begin
                                    word = {word[7:0], word[15:8]};
                                end
                                push_result(KIND_READ, 1'b0, 8'h00, word, 1'b1);
                            end
                        end else begin
                            push_result(KIND_READ, 1'b0, 8'h00, {8'h00, it.bus_byte}, 1'b1);
                        end
                    end
                end
                OP_END: begin
                    cs_active  = 1'b0;
                    in_read    = 1'b0;
                    skip_left  = 4'd0;
                    byte_index = 2'd0;
                    push_result(KIND_RELEASE, 1'b0, 8'h00, 16'h0000, 1'b1);
                end
                default: begin
                end
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= REPORT_CAP) begin
                    $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
                end
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP) begin
                    $display("%0t: result expected none, got kind %0d rs %0d bus %0h word %0h last %0d",
                             $time, got.kind, got.reg_select, got.bus_out, got.read_word, got.last);
                end
            end else begin
                want = expected_results.pop_front();
                compare_field("kind", want.kind, got.kind);
                compare_field("reg_select", want.reg_select, got.reg_select);
                compare_field("bus_out", want.bus_out, got.bus_out);
                compare_field("read_word", want.read_word, got.read_word);
                compare_field("last", want.last, got.last);
            end
        endfunction
    endclass

endpackage

@@ dv/tb.sv @@
// Testbench top that drives the display bus interface and checks every result item.
`timescale 1ns / 1ps

module tb;
    import plbi_pkg::*;
    import lcd_bus_check_pkg::*;

    // The slowest correct run is far below this: about four hundred items, each held up
    // only by random gaps and stalls.
    localparam int unsigned CYCLE_LIMIT = 300000;
    // Input register and queue latency plus margin, so items that yield no result have settled.
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned IDLE_PERCENT = 23;
    localparam logic [2:0] ADDR_SWAP_BYTE_ORDER = 3'd0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata, from bit 0: value[15:0], read_mode[17:16], dummy_count[21:18],
    // bus_byte[29:22], zero fill[31:30].
    logic [31:0] s_axis_tdata = '0;
    // tuser, from bit 0: op[2:0].
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata, from bit 0: bus_out[7:0], read_word[23:8].
    logic [23:0] m_axis_tdata;
    // tuser, from bit 0: kind[1:0], reg_select[2].
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // While calm is set neither side idles: this gives the back-to-back stretch of the run.
    logic              calm = 1'b0;
    int unsigned       cycles = 0;
    lcd_bus_scoreboard bus_board;

    parallel_lcd_bus_interface_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver stalls at random, except during the calm stretch.
    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Every result item taken at this edge goes to the scoreboard. The values read here are
    // the ones from before the edge, since the block updates through nonblocking assignments.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind       = t_kind'(m_axis_tuser[1:0]);
            got.reg_select = m_axis_tuser[2];
            got.bus_out    = m_axis_tdata[7:0];
            got.read_word  = m_axis_tdata[23:8];
            got.last       = m_axis_tlast;
            bus_board.check_result(got);
        end
    end

    // A hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Builds an item with every field random; callers then fix the fields that matter.
    // The unused fields stay random so the block is seen to ignore them.
    function automatic t_bus_item any_item(logic [2:0] op);
        t_bus_item it;
        it.op          = op;
        it.value       = 16'($urandom());
        it.read_mode   = 2'($urandom_range(0, 3));
        it.dummy_count = 4'($urandom_range(0, 15));
        it.bus_byte    = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // Offers one item and holds it until the block takes it. The valid stays high after
    // acceptance, so a following item reuses it without a lower-and-raise in one step.
    task automatic send_item(input t_bus_item it);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {2'b00, it.bus_byte, it.dummy_count, it.read_mode, it.value};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        bus_board.note_accepted_item(it);
    endtask

    task automatic send_write(input logic [2:0] op, input logic [15:0] value);
        t_bus_item it;
        it       = any_item(op);
        it.value = value;
        send_item(it);
    endtask

    task automatic send_begin(input logic [1:0] mode, input logic [3:0] count);
        t_bus_item it;
        it             = any_item(OP_BEGIN_READ);
        it.read_mode   = mode;
        it.dummy_count = count;
        send_item(it);
    endtask

    task automatic send_sample(input logic [7:0] sample);
        t_bus_item it;
        it          = any_item(OP_READ_BYTE);
        it.bus_byte = sample;
        send_item(it);
    endtask

    task automatic send_end();
        send_item(any_item(OP_END));
    endtask

    // Drops valid and waits until every predicted result has come back, then lets the
    // pipeline settle so that items without a result have also left it.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (bus_board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write: the setup phase, then the access phase until pready.
    task automatic write_swap(input logic swap);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SWAP_BYTE_ORDER;
        pwdata  <= {31'd0, swap};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        bus_board.set_swap(swap);
    endtask

    // Short hand-picked sequence: field extremes, every op and the corner cases of the
    // read phase.
    task automatic directed_cases();
        // A sample with no read phase open, then a release while already released.
        send_sample(8'h5A);
        send_end();
        // Eight-bit writes use only the low byte of value; sixteen-bit writes and an unused op follow.
        send_write(OP_CMD8, 16'hFF00);
        send_write(OP_CMD8, 16'h00FF);
        send_write(OP_CMD16, 16'hFFFF);
        send_write(OP_DATA16, 16'h0000);
        send_write(OP_DATA8, 16'hA5C3);
        send_item(any_item(OP_UNUSED));
        // Byte mode with no dummies.
        send_begin(RMODE_BYTE, 4'd0);
        send_sample(8'hFF);
        // Word mode behind one dummy byte.
        send_begin(RMODE_WORD, 4'd1);
        send_sample(8'h00);
        send_sample(8'hAB);
        send_sample(8'hCD);
        // RGB565 from three full-scale bytes.
        send_begin(RMODE_RGB565, 4'd0);
        send_sample(8'hFF);
        send_sample(8'hFF);
        send_sample(8'hFF);
        // The spare read mode assembles like byte mode.
        send_begin(RMODE_SPARE, 4'd0);
        send_sample(8'h81);
        // A write in mid-word drops the half-built read word.
        send_begin(RMODE_WORD, 4'd0);
        send_sample(8'h11);
        send_write(OP_DATA16, 16'hBEEF);
        // A second begin-read restarts the phase with the new mode.
        send_begin(RMODE_RGB565, 4'd0);
        send_sample(8'h7E);
        send_begin(RMODE_WORD, 4'd0);
        send_sample(8'h3C);
        send_sample(8'hC3);
        send_end();
    endtask

    // Mostly well-formed traffic: write items and read bursts of whole words behind their
    // dummy bytes, with some bursts cut short, stray samples and unused ops mixed in.
    task automatic random_traffic(input int unsigned count);
        int unsigned sent;
        int unsigned pick;
        int unsigned per_word;
        int unsigned total;
        logic [2:0]  op;
        logic [15:0] value;
        logic [1:0]  mode;
        logic [3:0]  skip;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                case ($urandom_range(0, 3))
                    0: op = OP_CMD8;
                    1: op = OP_CMD16;
                    2: op = OP_DATA8;
                    default: op = OP_DATA16;
                endcase
                if ($urandom_range(0, 9) == 0) begin
                    value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                end else begin
                    value = 16'($urandom());
                end
                send_write(op, value);
                sent++;
            end else if (pick < 80) begin
                case ($urandom_range(0, 9))
                    0: mode = RMODE_SPARE;
                    1, 2, 3: mode = RMODE_BYTE;
                    4, 5, 6: mode = RMODE_WORD;
                    default: mode = RMODE_RGB565;
                endcase
                skip = ($urandom_range(0, 19) == 0) ? 4'd15 : 4'($urandom_range(0, 2));
                send_begin(mode, skip);
                repeat (skip) send_sample(8'($urandom_range(0, 255)));
                per_word = (mode == RMODE_WORD) ? 2 : ((mode == RMODE_RGB565) ? 3 : 1);
                total = per_word * $urandom_range(1, 4);
                // Now and then the burst stops inside a word.
                if (per_word > 1 && $urandom_range(0, 4) == 0) begin
                    total = total - $urandom_range(1, per_word - 1);
                end
                repeat (total) send_sample(8'($urandom_range(0, 255)));
                sent += 1 + skip + total;
                if ($urandom_range(0, 2) == 0) begin
                    send_end();
                    sent++;
                end
            end else if (pick < 90) begin
                send_end();
                sent++;
            end else if ($urandom_range(0, 1) == 1) begin
                send_item(any_item(OP_UNUSED));
                sent++;
            end else begin
                send_sample(8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    initial begin
        bus_board = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed checks in the reset byte order, written explicitly.
        write_swap(1'b0);
        directed_cases();
        wait_for_drain();

        // Swapped byte order. The first part runs with no idling on either side, then
        // the sender holds off until every result is back before traffic resumes.
        write_swap(1'b1);
        calm = 1'b1;
        random_traffic(70);
        wait_for_drain();
        calm = 1'b0;
        random_traffic(60);
        wait_for_drain();

        // Back to high byte first, then swapped once more.
        write_swap(1'b0);
        random_traffic(130);
        wait_for_drain();
        write_swap(1'b1);
        random_traffic(130);
        wait_for_drain();

        if (bus_board.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
